### rtl/vlsm_pkg.sv
// shared types, constants and helper functions of the subnet allocator
package vlsm_pkg;

  localparam int MAX_SUBNETS = 32;
  localparam int IDX_W = $clog2(MAX_SUBNETS);
  localparam int CNT_W = $clog2(MAX_SUBNETS + 1);

  localparam logic [2:0] STATUS_OK       = 3'd0;
  localparam logic [2:0] STATUS_NO_SPACE = 3'd1;
  localparam logic [2:0] STATUS_FULL     = 3'd2;
  localparam logic [2:0] STATUS_ZERO     = 3'd3;
  localparam logic [2:0] STATUS_CLEARED  = 3'd4;

  localparam logic [0:0] REG_BASE_ADDRESS = 1'd0;
  localparam logic [0:0] REG_BASE_PREFIX  = 1'd1;

  typedef enum logic [3:0] {
    ST_IDLE, ST_SIZE, ST_CHECK, ST_SEEK, ST_MOVE, ST_FETCH, ST_SHOW,
    ST_CLEAR, ST_ZERO, ST_NO_SPACE, ST_FULL
  } vlsm_state_t;

  typedef struct packed {
    logic [7:0] tag;
    logic [4:0] size_bits;
  } vlsm_entry_t;

  typedef struct packed {
    logic       ready;
    logic       size_step;
    logic       start_shift;
    logic       seek;
    logic       move;
    logic       place;
    logic       start_emit;
    logic       fetch;
    logic       show;
    logic       reply;
    logic [2:0] code;
  } vlsm_cmd_t;

  typedef struct packed {
    logic in_fire;
    logic is_clear;
    logic zero_hosts;
    logic size_done;
    logic no_space;
    logic full;
    logic at_bottom;
    logic fits_above;
    logic last_entry;
    logic out_busy;
  } vlsm_stat_t;

  function automatic logic [4:0] eff_prefix(input logic [4:0] p);
    logic [4:0] r;
    r = p;
    if (p == 5'd0) r = 5'd1;
    if (p == 5'd31) r = 5'd30;
    return r;
  endfunction

  function automatic logic [31:0] pool_size(input logic [4:0] p);
    logic [5:0] sh;
    sh = 6'd32 - {1'b0, eff_prefix(p)};
    return 32'd1 << sh;
  endfunction

  function automatic logic [31:0] pool_mask(input logic [4:0] p);
    logic [5:0] sh;
    sh = 6'd32 - {1'b0, eff_prefix(p)};
    return 32'hFFFF_FFFF << sh;
  endfunction

endpackage

### rtl/vlsm_in_if.sv
// request channel of the subnet allocator
interface vlsm_in_if;
  logic        valid;
  logic        ready;
  logic        action;
  logic [7:0]  net_tag;
  logic [31:0] host_count;

  modport source (output valid, action, net_tag, host_count, input ready);
  modport sink (input valid, action, net_tag, host_count, output ready);
endinterface

### rtl/vlsm_out_if.sv
// result channel of the subnet allocator
interface vlsm_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [4:0]  position;
  logic [7:0]  entry_tag;
  logic [31:0] entry_address;
  logic [4:0]  entry_prefix;
  logic [31:0] free_addresses;
  logic        last;

  modport source (output valid, status, position, entry_tag, entry_address, entry_prefix,
                  free_addresses, last, input ready);
  modport sink (input valid, status, position, entry_tag, entry_address, entry_prefix,
                free_addresses, last, output ready);
endinterface

### rtl/vlsm_ctrl.sv
// controller state machine of the subnet allocator
module vlsm_ctrl import vlsm_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  vlsm_stat_t stat,
  output vlsm_cmd_t  cmd
);

  vlsm_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (stat.in_fire) state_next = ST_SIZE;
      end
      ST_SIZE: begin
        if (stat.is_clear) state_next = ST_CLEAR;
        else if (stat.zero_hosts) state_next = ST_ZERO;
        else if (stat.size_done) state_next = ST_CHECK;
      end
      ST_CHECK: begin
        if (stat.no_space) state_next = ST_NO_SPACE;
        else if (stat.full) state_next = ST_FULL;
        else state_next = ST_SEEK;
      end
      ST_SEEK: begin
        if (stat.at_bottom) state_next = ST_FETCH;
        else state_next = ST_MOVE;
      end
      ST_MOVE: begin
        if (stat.fits_above) state_next = ST_FETCH;
        else state_next = ST_SEEK;
      end
      ST_FETCH: state_next = ST_SHOW;
      ST_SHOW: begin
        if (!stat.out_busy) state_next = stat.last_entry ? ST_IDLE : ST_FETCH;
      end
      ST_CLEAR, ST_ZERO, ST_NO_SPACE, ST_FULL: begin
        if (!stat.out_busy) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    cmd.code = STATUS_OK;
    case (state)
      ST_IDLE: cmd.ready = 1'b1;
      ST_SIZE: begin
        if (!stat.is_clear && !stat.zero_hosts && !stat.size_done) cmd.size_step = 1'b1;
      end
      ST_CHECK: begin
        if (!stat.no_space && !stat.full) cmd.start_shift = 1'b1;
      end
      ST_SEEK: begin
        if (stat.at_bottom) begin
          cmd.place = 1'b1;
          cmd.start_emit = 1'b1;
        end else begin
          cmd.seek = 1'b1;
        end
      end
      ST_MOVE: begin
        if (stat.fits_above) begin
          cmd.place = 1'b1;
          cmd.start_emit = 1'b1;
        end else begin
          cmd.move = 1'b1;
        end
      end
      ST_FETCH: cmd.fetch = 1'b1;
      ST_SHOW: cmd.show = !stat.out_busy;
      ST_CLEAR: begin
        cmd.reply = !stat.out_busy;
        cmd.code = STATUS_CLEARED;
      end
      ST_ZERO: begin
        cmd.reply = !stat.out_busy;
        cmd.code = STATUS_ZERO;
      end
      ST_NO_SPACE: begin
        cmd.reply = !stat.out_busy;
        cmd.code = STATUS_NO_SPACE;
      end
      ST_FULL: begin
        cmd.reply = !stat.out_busy;
        cmd.code = STATUS_FULL;
      end
      default: cmd = '0;
    endcase
  end

endmodule

### rtl/vlsm_dpath.sv
// datapath of the subnet allocator: registers, entry table and result register
module vlsm_dpath import vlsm_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [31:0] cfg_data,
  vlsm_in_if.sink     in_ch,
  vlsm_out_if.source  out_ch,
  input  vlsm_cmd_t   cmd,
  output vlsm_stat_t  stat
);

  vlsm_entry_t mem [MAX_SUBNETS];
  vlsm_entry_t rd_data;

  logic [31:0]      base_address;
  logic [4:0]       base_prefix;
  logic [CNT_W-1:0] count;
  logic [31:0]      free;
  logic             action;
  logic [7:0]       tag;
  logic [32:0]      rem;
  logic [5:0]       bits;
  logic             zero_hosts;
  logic [CNT_W-1:0] idx;
  logic [31:0]      addr_acc;
  logic             out_valid;
  logic [31:0]      block;
  logic [CNT_W-1:0] idx_dec;
  logic [IDX_W-1:0] rd_addr;
  logic             in_fire;

  assign in_ch.ready = cmd.ready;
  assign in_fire     = in_ch.valid && cmd.ready;
  assign block       = 32'd1 << bits[4:0];
  assign idx_dec     = idx - CNT_W'(1);
  assign rd_addr     = cmd.seek ? idx_dec[IDX_W-1:0] : idx[IDX_W-1:0];

  assign stat.in_fire    = in_fire;
  assign stat.is_clear   = action;
  assign stat.zero_hosts = zero_hosts;
  assign stat.size_done  = (rem == 33'd0);
  assign stat.no_space   = (bits > 6'd31) || (block > free);
  assign stat.full       = (count >= CNT_W'(MAX_SUBNETS));
  assign stat.at_bottom  = (idx == '0);
  assign stat.fits_above = ({1'b0, rd_data.size_bits} >= bits);
  assign stat.last_entry = (idx + CNT_W'(1) == count);
  assign stat.out_busy   = out_valid;

  always_ff @(posedge clk) begin
    if (cmd.seek || cmd.fetch) rd_data <= mem[rd_addr];
    if (cmd.move) mem[idx[IDX_W-1:0]] <= rd_data;
    if (cmd.place) mem[idx[IDX_W-1:0]] <= '{tag: tag, size_bits: bits[4:0]};
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      action     <= in_ch.action;
      tag        <= in_ch.net_tag;
      rem        <= {1'b0, in_ch.host_count} + 33'd1;
      bits       <= '0;
      zero_hosts <= (in_ch.host_count == 32'd0);
    end
    if (cmd.size_step) begin
      rem  <= rem >> 1;
      bits <= bits + 6'd1;
    end
    if (cmd.start_shift) idx <= count;
    if (cmd.move) idx <= idx_dec;
    if (cmd.start_emit) begin
      idx      <= '0;
      addr_acc <= base_address & pool_mask(base_prefix);
    end
    if (cmd.show) begin
      out_ch.status         <= STATUS_OK;
      out_ch.position       <= idx[4:0];
      out_ch.entry_tag      <= rd_data.tag;
      out_ch.entry_address  <= addr_acc;
      out_ch.entry_prefix   <= 5'(6'd32 - {1'b0, rd_data.size_bits});
      out_ch.free_addresses <= free;
      out_ch.last           <= stat.last_entry;
      addr_acc              <= addr_acc + (32'd1 << rd_data.size_bits);
      idx                   <= idx + CNT_W'(1);
    end
    if (cmd.reply) begin
      out_ch.status         <= cmd.code;
      out_ch.position       <= '0;
      out_ch.entry_tag      <= '0;
      out_ch.entry_address  <= '0;
      out_ch.entry_prefix   <= '0;
      out_ch.free_addresses <= (cmd.code == STATUS_CLEARED) ? pool_size(base_prefix) : free;
      out_ch.last           <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      base_address <= '0;
      base_prefix  <= 5'd24;
      count        <= '0;
      free         <= pool_size(5'd24);
      out_valid    <= 1'b0;
    end else begin
      if (out_valid && out_ch.ready) out_valid <= 1'b0;
      if (cmd.show || cmd.reply) out_valid <= 1'b1;
      if (cmd.place) begin
        count <= count + CNT_W'(1);
        free  <= free - block;
      end
      if (cmd.reply && cmd.code == STATUS_CLEARED) begin
        count <= '0;
        free  <= pool_size(base_prefix);
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_BASE_ADDRESS: begin
            base_address <= cfg_data;
            count        <= '0;
            free         <= pool_size(base_prefix);
          end
          REG_BASE_PREFIX: begin
            base_prefix <= cfg_data[4:0];
            count       <= '0;
            free        <= pool_size(cfg_data[4:0]);
          end
          default: count <= count;
        endcase
      end
    end
  end

  assign out_ch.valid = out_valid;

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(MAX_SUBNETS)) else $error("entry count beyond table depth");
  a_place_room: assert property (@(posedge clk) disable iff (rst)
    cmd.place |-> count < CNT_W'(MAX_SUBNETS)) else $error("insert into full table");
  a_show_range: assert property (@(posedge clk) disable iff (rst)
    cmd.show |-> idx < count) else $error("report beyond table end");
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (cmd.show || cmd.reply) |-> !out_valid) else $error("result register overwritten");
`endif

endmodule

### rtl/vlsm_subnet_allocator.sv
// top level of the subnet allocator: controller plus datapath
// Takes one request at a time. A clear or a zero host count gives its one result from the
// clear or zero state. Any other add sizes the block one bit per cycle and checks it; a
// rejected add gives its result from the no-space or full state. An accepted add shifts the
// sorted table through the seek and move states per moved entry of the single-port entry
// memory, then reports every entry through the fetch and show states, waiting out any stall
// on the result side. A new request is taken once the last result sits in the output register.
module vlsm_subnet_allocator import vlsm_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [31:0] cfg_data,
  vlsm_in_if.sink     in_ch,
  vlsm_out_if.source  out_ch
);

  vlsm_cmd_t  cmd;
  vlsm_stat_t stat;

  vlsm_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .stat (stat),
    .cmd  (cmd)
  );

  vlsm_dpath u_dpath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cmd       (cmd),
    .stat      (stat)
  );

endmodule
